[src/wbps_pkg.sv]
package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 64;
	localparam int PATTERN_MAX_CAP = 4096;

	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 48;
	localparam int CNT_W   = 9;
	localparam int LIMIT_W = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);
	localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(256);

	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_MATCH_LIMIT = APB_AW'(0);

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_SCAN = 1'b1
	} req_type_t;

	typedef struct packed {
		logic scan;
		logic load;
		logic restart;
	} cell_ctrl_t;

endpackage

[src/wbps_if.sv]
interface wbps_req_if;
	import wbps_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [BYTE_W-1:0] entry_value;
	logic              entry_wildcard;
	logic              entry_first;
	logic [BYTE_W-1:0] mem_byte;
	logic [ADDR_W-1:0] mem_address;
	logic              region_head;

	modport source (
		output valid, req_type, entry_value, entry_wildcard, entry_first,
		       mem_byte, mem_address, region_head,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_value, entry_wildcard, entry_first,
		       mem_byte, mem_address, region_head,
		output ready
	);
endinterface

interface wbps_rsp_if;
	import wbps_pkg::*;

	logic              valid;
	logic              ready;
	logic              match;
	logic [ADDR_W-1:0] match_address;
	logic [CNT_W-1:0]  matches_found;
	logic              limit_reached;
	logic              pattern_overflow;

	modport source (
		output valid, match, match_address, matches_found, limit_reached,
		       pattern_overflow,
		input  ready
	);
	modport sink (
		input  valid, match, match_address, matches_found, limit_reached,
		       pattern_overflow,
		output ready
	);
endinterface

[src/wbps_cell.sv]
module wbps_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wbps_pkg::cell_ctrl_t      ctrl,
	input  logic [wbps_pkg::BYTE_W-1:0] scan_byte,
	input  logic                      wr_en,
	input  logic [wbps_pkg::BYTE_W-1:0] wr_value,
	input  logic                      wr_wild,
	input  logic                      link_in,
	input  logic                      next_active,
	output logic                      active,
	output logic                      pm,
	output logic                      hit
);
	import wbps_pkg::*;

	logic [BYTE_W-1:0] value_q;
	logic              wild_q;
	logic              active_q;
	logic              pm_q;
	logic              pm_next;

	// cell is in the pattern and the new byte fits its entry
	assign pm_next = link_in & active_q & (wild_q | (value_q == scan_byte));
	// last active cell closes a full match
	assign hit     = pm_next & active_q & ~next_active;
	assign active  = active_q;
	assign pm      = pm_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_q <= wr_value;
			wild_q  <= wr_wild;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pm_q     <= 1'b0;
		end else if (ctrl.load) begin
			active_q <= ctrl.restart ? wr_en : (active_q | wr_en);
			pm_q     <= 1'b0;
		end else if (ctrl.scan) begin
			pm_q <= pm_next;
		end
	end

endmodule

[src/wildcard_byte_pattern_scanner.sv]
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; each byte updates the whole cell row at
// once and the result sits in a single output register, so the only
// stall is a result not yet taken.
// Reset (arst_n low): pattern empty, partial matches, count and overflow
// cleared, match_limit back to 32; pattern bytes stay unknown until loaded.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	wbps_req_if.sink                    request,
	wbps_rsp_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbps_pkg::APB_AW-1:0] paddr,
	input  logic [wbps_pkg::APB_DW-1:0] pwdata,
	output logic [wbps_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] eff_limit;
	logic [LEN_W-1:0]   len_q;
	logic [CNT_W-1:0]   count_q;
	logic               overflow_q;

	logic               accept;
	logic               is_load;
	logic               is_scan;
	logic               pat_full;
	logic               do_write;
	logic [IDX_W-1:0]   wr_idx;
	cell_ctrl_t         ctrl;

	logic [PATTERN_MAX-1:0] wr_sel;
	logic [PATTERN_MAX-1:0] link;
	logic [PATTERN_MAX-1:0] next_act;
	logic [PATTERN_MAX-1:0] act;
	logic [PATTERN_MAX-1:0] pm;
	logic [PATTERN_MAX-1:0] hit_vec;

	logic               full_any;
	logic               hit;
	logic [CNT_W-1:0]   count_next;
	logic               overflow_next;
	logic [LEN_W-1:0]   len_next;
	logic [ADDR_W-1:0]  start_addr;

	logic               valid_q;
	logic               match_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]   found_q;
	logic               reached_q;
	logic               ovf_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MATCH_LIMIT) ? APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr == REG_MATCH_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		priority if (limit_q == '0)
			eff_limit = LIMIT_W'(1);
		else if (limit_q > LIMIT_CAP)
			eff_limit = LIMIT_CAP;
		else
			eff_limit = limit_q;
	end

	// request handshake
	assign request.ready = ~valid_q | result.ready;
	assign accept        = request.valid & request.ready;
	assign is_load       = accept & (request.req_type == REQ_LOAD);
	assign is_scan       = accept & (request.req_type == REQ_SCAN);

	assign pat_full = ~request.entry_first & (len_q == LEN_W'(PATTERN_MAX));
	assign do_write = is_load & ~pat_full;
	assign wr_idx   = request.entry_first ? '0 : len_q[IDX_W-1:0];

	assign ctrl.scan    = is_scan;
	assign ctrl.load    = is_load;
	assign ctrl.restart = request.entry_first;

	// cell row: bit i advances from bit i-1, the head always enters
	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			assign wr_sel[gi] = do_write & (wr_idx == IDX_W'(gi));
			if (gi == 0) begin : g_head
				assign link[gi] = 1'b1;
			end else begin : g_body
				assign link[gi] = pm[gi-1] & ~request.region_head;
			end
			if (gi == PATTERN_MAX - 1) begin : g_tail
				assign next_act[gi] = 1'b0;
			end else begin : g_mid
				assign next_act[gi] = act[gi+1];
			end

			wbps_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.scan_byte  (request.mem_byte),
				.wr_en      (wr_sel[gi]),
				.wr_value   (request.entry_value),
				.wr_wild    (request.entry_wildcard),
				.link_in    (link[gi]),
				.next_active(next_act[gi]),
				.active     (act[gi]),
				.pm         (pm[gi]),
				.hit        (hit_vec[gi])
			);
		end
	endgenerate

	assign full_any   = |hit_vec;
	assign hit        = is_scan & full_any & (count_q < eff_limit);
	assign start_addr = request.mem_address - ADDR_W'(len_q) + ADDR_W'(1);

	always_comb begin
		count_next    = count_q;
		overflow_next = overflow_q;
		len_next      = len_q;
		if (is_load) begin
			if (request.entry_first) begin
				count_next    = '0;
				overflow_next = 1'b0;
				len_next      = LEN_W'(1);
			end else if (pat_full) begin
				overflow_next = 1'b1;
			end else begin
				len_next = len_q + LEN_W'(1);
			end
		end else if (hit) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				len_q      <= len_next;
				count_q    <= count_next;
				overflow_q <= overflow_next;
				valid_q    <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_q   <= hit;
			addr_q    <= hit ? start_addr : '0;
			found_q   <= count_next;
			reached_q <= (count_next >= eff_limit);
			ovf_q     <= overflow_next;
		end
	end

	assign result.valid            = valid_q;
	assign result.match            = match_q;
	assign result.match_address    = addr_q;
	assign result.matches_found    = found_q;
	assign result.limit_reached    = reached_q;
	assign result.pattern_overflow = ovf_q;

endmodule

[dv/wildcard_byte_pattern_scanner_tb.sv]
module wildcard_byte_pattern_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wbps_pkg::*;

	localparam int PAT_MAX = PATTERN_MAX_DEF;
	localparam int RANDOM_ITEMS = 830;
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		req_type_t         kind;
		logic [BYTE_W-1:0] ev;
		logic              wild;
		logic              first;
		logic [BYTE_W-1:0] mb;
		logic [ADDR_W-1:0] ma;
		logic              rs;
	} scan_req_t;

	typedef struct packed {
		logic              match;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  found;
		logic              lim;
		logic              ovf;
	} scan_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	wbps_req_if req_bus ();
	wbps_rsp_if rsp_bus ();

	wildcard_byte_pattern_scanner uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_bus),
		.result  (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// scanner shadow state
	bit [BYTE_W-1:0]      pat_val [PAT_MAX];
	bit                   pat_wild [PAT_MAX];
	int                   pat_len;
	logic [PAT_MAX-1:0]   live_partials;
	logic [CNT_W-1:0]     hit_count;
	logic                 ovf_flag;
	logic [LIMIT_W-1:0]   match_limit_q;

	scan_result_t pending_results [$];
	int mismatch_count;
	int items_sent;
	int cycle_count;
	bit sender_no_gaps;
	bit sink_no_stalls;
	int long_hold_cycles;
	logic [ADDR_W-1:0] next_addr;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int eff_limit();
		if (match_limit_q == 0) return 1;
		if (match_limit_q > LIMIT_CAP) return int'(LIMIT_CAP);
		return int'(match_limit_q);
	endfunction

	function automatic scan_result_t predict_scan(scan_req_t r);
		scan_result_t res;
		logic [PAT_MAX-1:0] nxt;
		int top;
		int i;
		res = '0;
		if (r.kind == REQ_LOAD) begin
			if (r.first) begin
				pat_len = 0;
				hit_count = '0;
				ovf_flag = 1'b0;
			end
			live_partials = '0;
			if (pat_len < PAT_MAX) begin
				pat_val[pat_len] = r.ev;
				pat_wild[pat_len] = r.wild;
				pat_len++;
			end else begin
				ovf_flag = 1'b1;
			end
		end else begin
			if (r.rs) live_partials = '0;
			nxt = {live_partials[PAT_MAX-2:0], 1'b1};
			for (i = 0; i < PAT_MAX; i++) begin
				if (!(i < pat_len && (pat_wild[i] || pat_val[i] == r.mb))) nxt[i] = 1'b0;
			end
			live_partials = nxt;
			if (pat_len > 0) begin
				top = pat_len - 1;
				if (live_partials[top] && int'(hit_count) < eff_limit()) begin
					res.match = 1'b1;
					hit_count++;
					res.addr = r.ma - ADDR_W'(top);
				end
			end
		end
		res.found = hit_count;
		res.lim = int'(hit_count) >= eff_limit();
		res.ovf = ovf_flag;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		scan_req_t seen;
		scan_result_t got;
		scan_result_t want;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				seen.kind = req_type_t'(req_bus.req_type);
				seen.ev = req_bus.entry_value;
				seen.wild = req_bus.entry_wildcard;
				seen.first = req_bus.entry_first;
				seen.mb = req_bus.mem_byte;
				seen.ma = req_bus.mem_address;
				seen.rs = req_bus.region_head;
				pending_results = {pending_results, predict_scan(seen)};
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				got = {rsp_bus.match, rsp_bus.match_address, rsp_bus.matches_found,
					rsp_bus.limit_reached, rsp_bus.pattern_overflow};
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected result: match=%0b addr=%h found=%0d",
							got.match, got.addr, got.found);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"mismatch: expected match=%0b addr=%h found=%0d lim=%0b ",
								"ovf=%0b, got match=%0b addr=%h found=%0d lim=%0b ovf=%0b"},
								want.match, want.addr, want.found, want.lim, want.ovf,
								got.match, got.addr, got.found, got.lim, got.ovf);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result sink: random stalls, plus a long hold-off when one is requested
	initial begin
		int stall;
		rsp_bus.ready = 1'b0;
		forever begin
			stall = sink_no_stalls ? 0 : $urandom_range(0, 17);
			if (long_hold_cycles > 0) begin
				stall = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	task automatic send_req(scan_req_t item);
		int gap;
		gap = sender_no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= item.kind;
		req_bus.entry_value <= item.ev;
		req_bus.entry_wildcard <= item.wild;
		req_bus.entry_first <= item.first;
		req_bus.mem_byte <= item.mb;
		req_bus.mem_address <= item.ma;
		req_bus.region_head <= item.rs;
		do @(posedge clk); while (!req_bus.ready);
		items_sent++;
	endtask

	task automatic send_scan(bit [BYTE_W-1:0] b, bit rs);
		scan_req_t item;
		item.kind = REQ_SCAN;
		item.ev = BYTE_W'($urandom);
		item.wild = 1'($urandom);
		item.first = 1'($urandom);
		item.mb = b;
		item.ma = next_addr;
		item.rs = rs;
		next_addr++;
		send_req(item);
	endtask

	task automatic send_load(bit [BYTE_W-1:0] v, bit w, bit first);
		scan_req_t item;
		item.kind = REQ_LOAD;
		item.ev = v;
		item.wild = w;
		item.first = first;
		item.mb = BYTE_W'($urandom);
		item.ma = ADDR_W'({$urandom, $urandom});
		item.rs = 1'($urandom);
		send_req(item);
	endtask

	task automatic wait_until_idle();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MATCH_LIMIT;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		match_limit_q = value;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return LIMIT_W'(1);
			2: return LIMIT_CAP;
			3: return '1;
			4: return LIMIT_RESET;
			5: return LIMIT_W'(2);
			default: return LIMIT_W'($urandom_range(2, 40));
		endcase
	endfunction

	task automatic test_directed();
		// empty pattern at the top address
		next_addr = '1;
		send_scan(8'hFF, 1'b1);
		send_load(8'h00, 1'b0, 1'b1);
		send_load(8'hFF, 1'b0, 1'b0);
		send_load(8'h5A, 1'b1, 1'b0);
		send_load(8'h80, 1'b0, 1'b0);
		// match whose start lies just below the address wrap
		next_addr = 48'hFFFF_FFFF_FFFE;
		send_scan(8'h00, 1'b1);
		send_scan(8'hFF, 1'b0);
		send_scan(8'h13, 1'b0);
		send_scan(8'h80, 1'b0);
		// region break drops the partial match
		send_scan(8'h00, 1'b0);
		send_scan(8'hFF, 1'b0);
		send_scan(8'h33, 1'b1);
		send_scan(8'h80, 1'b0);
		// overlapping matches from address zero
		send_load(8'h41, 1'b0, 1'b1);
		send_load(8'hC3, 1'b1, 1'b0);
		next_addr = '0;
		send_scan(8'h41, 1'b1);
		send_scan(8'h41, 1'b0);
		send_scan(8'h41, 1'b0);
		// appending an entry clears what was partly matched
		send_scan(8'h41, 1'b0);
		send_load(8'h42, 1'b0, 1'b0);
		send_scan(8'h99, 1'b0);
		send_scan(8'h42, 1'b0);
		send_scan(8'h41, 1'b0);
		send_scan(8'h07, 1'b0);
		send_scan(8'h42, 1'b0);
	endtask

	task automatic test_match_limit();
		int k;
		wait_until_idle();
		write_limit('0);
		send_load(8'h00, 1'b1, 1'b1);
		repeat (3) send_scan(BYTE_W'($urandom), 1'b0);
		wait_until_idle();
		write_limit('1);
		sender_no_gaps = 1'b1;
		send_load(8'hFF, 1'b1, 1'b1);
		for (k = 0; k < 260; k++) send_scan(BYTE_W'($urandom), k == 100);
		wait_until_idle();
		write_limit(LIMIT_CAP);
		send_load(8'h00, 1'b1, 1'b1);
		for (k = 0; k < 258; k++) send_scan(BYTE_W'($urandom), 1'b0);
		wait_until_idle();
		write_limit(LIMIT_W'(1));
		sender_no_gaps = 1'b0;
		send_load(8'h7E, 1'b0, 1'b1);
		repeat (3) send_scan(8'h7E, 1'b0);
		wait_until_idle();
		write_limit(LIMIT_RESET);
	endtask

	task automatic test_pattern_overflow();
		int k;
		for (k = 0; k < PAT_MAX + 2; k++)
			send_load(8'hA5, k % 16 != 0, k == 0);
		next_addr = ADDR_W'({$urandom, $urandom});
		for (k = 0; k < 70; k++)
			send_scan(k % 16 == 0 ? 8'hA5 : BYTE_W'($urandom), k == 0);
		// restart clears the overflow flag
		send_load(8'hA5, 1'b0, 1'b1);
		send_scan(8'hA5, 1'b0);
	endtask

	task automatic test_backpressure();
		int k;
		wait_until_idle();
		sender_no_gaps = 1'b1;
		sink_no_stalls = 1'b1;
		send_load(8'h00, 1'b1, 1'b1);
		long_hold_cycles = 300;
		for (k = 0; k < 40; k++) send_scan(BYTE_W'($urandom), 1'b0);
		long_hold_cycles = 150;
		for (k = 0; k < 40; k++) send_scan(BYTE_W'($urandom), 1'b0);
		sender_no_gaps = 1'b0;
		sink_no_stalls = 1'b0;
	endtask

	task automatic test_random_scans();
		int len;
		int scan_len;
		int k;
		int j;
		int pick;
		int seq;
		int stop_at;
		bit [BYTE_W-1:0] alpha [3];
		bit [BYTE_W-1:0] pv [$];
		bit pw [$];
		bit rs_pending;
		bit broken;
		stop_at = items_sent + RANDOM_ITEMS;
		seq = 0;
		while (items_sent < stop_at) begin
			if (seq % 6 == 5) begin
				wait_until_idle();
				write_limit(pick_limit());
			end
			sender_no_gaps = $urandom_range(0, 3) == 0;
			sink_no_stalls = $urandom_range(0, 3) == 0;
			pick = $urandom_range(0, 19);
			if (pick < 14) len = $urandom_range(1, 5);
			else if (pick < 18) len = $urandom_range(6, 16);
			else if (pick < 19) len = $urandom_range(17, PAT_MAX);
			else len = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
			for (k = 0; k < 3; k++)
				alpha[k] = $urandom_range(0, 3) == 0 ? {BYTE_W{$urandom_range(0, 1) == 1}}
					: BYTE_W'($urandom);
			pv.delete();
			pw.delete();
			for (k = 0; k < len; k++) begin
				pw = {pw, (len > 16 ? $urandom_range(0, 9) < 6 : $urandom_range(0, 3) == 0)};
				pv = {pv, alpha[$urandom_range(0, 2)]};
			end
			// occasionally append to whatever pattern is held
			broken = $urandom_range(0, 9) == 0;
			for (k = 0; k < len; k++) send_load(pv[k], pw[k], k == 0 && !broken);
			if ($urandom_range(0, 3) == 0) next_addr = '1 - ADDR_W'($urandom_range(0, 40));
			else next_addr = ADDR_W'({$urandom, $urandom});
			rs_pending = $urandom_range(0, 1);
			scan_len = 2 * len + $urandom_range(10, 40);
			k = 0;
			while (k < scan_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					for (j = 0; j < len; j++) begin
						send_scan(pw[j] ? BYTE_W'($urandom) : pv[j], rs_pending);
						rs_pending = 1'b0;
					end
					k += len;
				end else if (pick < 38) begin
					send_load(BYTE_W'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
					k++;
				end else begin
					if (pick < 42) rs_pending = 1'b1;
					send_scan(pick < 90 ? alpha[$urandom_range(0, 2)] : BYTE_W'($urandom),
						rs_pending);
					rs_pending = 1'b0;
					k++;
				end
			end
			seq++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_LOAD;
		req_bus.entry_value = '0;
		req_bus.entry_wildcard = 1'b0;
		req_bus.entry_first = 1'b0;
		req_bus.mem_byte = '0;
		req_bus.mem_address = '0;
		req_bus.region_head = 1'b0;
		pat_len = 0;
		live_partials = '0;
		hit_count = '0;
		ovf_flag = 1'b0;
		match_limit_q = LIMIT_RESET;
		mismatch_count = 0;
		items_sent = 0;
		cycle_count = 0;
		sender_no_gaps = 1'b0;
		sink_no_stalls = 1'b0;
		long_hold_cycles = 0;
		next_addr = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_match_limit();
		test_pattern_overflow();
		test_backpressure();
		test_random_scans();

		wait_until_idle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
src/wbps_pkg.sv
src/wbps_if.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_scanner.sv
dv/wildcard_byte_pattern_scanner_tb.sv
